[rtl/core/swdh_pkg.sv]
`default_nettype none

package swdh_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned CountW = 8;
	localparam int unsigned CfgW   = 8;
	localparam int unsigned CfgIdxW = 2;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_TURNAROUND = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_FORCE_DATA = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_IDLE_COUNT = 2'd2;

	// status codes reported on the last period of a transfer
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_WAIT     = 3'd1;
	localparam logic [2:0] ST_FAULT    = 3'd2;
	localparam logic [2:0] ST_PROTOCOL = 3'd3;
	localparam logic [2:0] ST_PARITY   = 3'd4;

	// ACK codes as sampled LSB first
	localparam logic [2:0] ACK_OK    = 3'b001;
	localparam logic [2:0] ACK_WAIT  = 3'b010;
	localparam logic [2:0] ACK_FAULT = 3'b100;

	localparam logic [7:0] HDR_FIXED = 8'h81;

	typedef enum logic [14:0] {
		PH_IDLE    = 15'b000_0000_0000_0001,
		PH_HDR     = 15'b000_0000_0000_0010,
		PH_ACK     = 15'b000_0000_0000_0100,
		PH_RDATA   = 15'b000_0000_0000_1000,
		PH_RPAR    = 15'b000_0000_0001_0000,
		PH_RTURN   = 15'b000_0000_0010_0000,
		PH_WTURN   = 15'b000_0000_0100_0000,
		PH_WDATA   = 15'b000_0000_1000_0000,
		PH_WPAR    = 15'b000_0001_0000_0000,
		PH_IDLEZ   = 15'b000_0010_0000_0000,
		PH_DUMR    = 15'b000_0100_0000_0000,
		PH_TURN    = 15'b000_1000_0000_0000,
		PH_DUMW    = 15'b001_0000_0000_0000,
		PH_TURNW   = 15'b010_0000_0000_0000,
		PH_BACKOFF = 15'b100_0000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]        turnaround_len;
		logic              force_data_phase;
		logic [CountW-1:0] idle_count;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [CountW-1:0] bit_count;
		logic [DataW-1:0]  shift_reg;
		logic [7:0]        header_byte;
		logic              parity_acc;
		logic [2:0]        ack_reg;
		logic              req_is_read;
	} eng_state_t;

	typedef struct packed {
		logic             swdio_out;
		logic             swdio_drive;
		logic             busy_res;
		logic             done_res;
		logic [2:0]       status;
		logic [DataW-1:0] rdata;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		turnaround_len:   3'd1,
		force_data_phase: 1'b0,
		idle_count:       '0
	};

endpackage

`default_nettype wire

[rtl/core/swdh_in_if.sv]
`default_nettype none

interface swdh_in_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic        ap_select;
	logic        is_read;
	logic [1:0]  reg_addr;
	logic [31:0] wdata;
	logic        swdio_in;

	modport source (
		output valid, start_req, ap_select, is_read, reg_addr, wdata, swdio_in,
		input  ready
	);
	modport sink (
		input  valid, start_req, ap_select, is_read, reg_addr, wdata, swdio_in,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/swdh_out_if.sv]
`default_nettype none

interface swdh_out_if;
	logic        valid;
	logic        ready;
	logic        swdio_out;
	logic        swdio_drive;
	logic        busy_res;
	logic        done_res;
	logic [2:0]  status;
	logic [31:0] rdata;

	modport source (
		output valid, swdio_out, swdio_drive, busy_res, done_res, status, rdata,
		input  ready
	);
	modport sink (
		input  valid, swdio_out, swdio_drive, busy_res, done_res, status, rdata,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/swd_host_transfer_engine_unit.sv]
`default_nettype none

// SWD host transfer engine.
// Every request on req_in stands for one SWCLK period: it carries the start
// controls, the write data and the SWDIO level sampled in that period. Every
// request yields exactly one result on res_out with the level to drive, the
// drive enable, busy, done and, on done, the status and read data.
// A start seen while idle latches the transfer and sends the first header bit
// in the same period; starts during a transfer are ignored.
// A result is registered and shows in the cycle after its request is taken.
// Throughput: one request per cycle unless res_out stalls; the sequencer
// state advances in one step between the state and result registers.
// req_in.ready is high whenever the result register is empty or being taken,
// so a stalled receiver holds one result and back-pressures the request side.
// Configuration writes (turnaround, forced data phase, idle count) are to be
// made while no request is in flight; the block itself does not enforce it.
// Reset: sequencer idle, result register empty, turnaround 1, no forced data
// phase, no idle tail.
module swd_host_transfer_engine_unit
	import swdh_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	swdh_in_if.sink                 req_in,
	swdh_out_if.source              res_out,
	input  wire logic               cfg_wr_en,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_wdata
);

	cfg_t       cfg;
	eng_state_t state_q;
	eng_state_t state_nxt;
	result_t    step_res;
	result_t    res_q;
	logic       res_valid_q;
	logic       take;

	swdh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	swdh_step u_step (
		.cur       (state_q),
		.cfg       (cfg),
		.start_req (req_in.start_req),
		.ap_select (req_in.ap_select),
		.is_read   (req_in.is_read),
		.reg_addr  (req_in.reg_addr),
		.wdata     (req_in.wdata),
		.swdio_in  (req_in.swdio_in),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	assign req_in.ready = !res_valid_q || res_out.ready;
	assign take = req_in.valid && req_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= step_res;
		end
	end

	assign res_out.valid       = res_valid_q;
	assign res_out.swdio_out   = res_q.swdio_out;
	assign res_out.swdio_drive = res_q.swdio_drive;
	assign res_out.busy_res    = res_q.busy_res;
	assign res_out.done_res    = res_q.done_res;
	assign res_out.status      = res_q.status;
	assign res_out.rdata       = res_q.rdata;

endmodule

`default_nettype wire

[rtl/core/swdh_cfg_regs.sv]
`default_nettype none

module swdh_cfg_regs
	import swdh_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_wdata,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TURNAROUND: cfg_q.turnaround_len <= cfg_wdata[2:0];
				REG_FORCE_DATA: cfg_q.force_data_phase <= cfg_wdata[0];
				REG_IDLE_COUNT: cfg_q.idle_count <= cfg_wdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/swdh_step.sv]
`default_nettype none

// One SWCLK period of the transfer sequencer: next state and line/result values.
module swdh_step
	import swdh_pkg::*;
(
	input  wire eng_state_t        cur,
	input  wire cfg_t              cfg,
	input  wire logic              start_req,
	input  wire logic              ap_select,
	input  wire logic              is_read,
	input  wire logic [1:0]        reg_addr,
	input  wire logic [DataW-1:0]  wdata,
	input  wire logic              swdio_in,
	output eng_state_t             nxt,
	output result_t                res
);

	logic [2:0]        turn;
	logic [3:0]        req;
	logic              active;
	logic [CountW-1:0] ack_pos;
	logic [CountW:0]   cnt_inc;
	logic [CountW:0]   len;
	phase_t            np;
	logic              done;

	// turnaround clamped to 1..4
	always_comb begin
		if (cfg.turnaround_len == 3'd0) begin
			turn = 3'd1;
		end else if (cfg.turnaround_len > 3'd4) begin
			turn = 3'd4;
		end else begin
			turn = cfg.turnaround_len;
		end
	end

	assign req    = {reg_addr, is_read, ap_select};
	assign active = (cur.phase != PH_IDLE) || start_req;

	always_comb begin
		nxt = cur;
		res = '0;
		res.swdio_drive = 1'b1;
		ack_pos = '0;
		cnt_inc = '0;
		len = '0;
		np = PH_IDLE;
		done = 1'b0;

		if (cur.phase == PH_IDLE && start_req) begin
			nxt.phase       = PH_HDR;
			nxt.header_byte = HDR_FIXED | {2'b00, ^req, req, 1'b0};
			nxt.req_is_read = is_read;
			nxt.shift_reg   = is_read ? '0 : wdata;
			nxt.parity_acc  = is_read ? 1'b0 : ^wdata;
			nxt.ack_reg     = '0;
			nxt.bit_count   = '0;
		end

		if (active) begin
			res.busy_res = 1'b1;

			case (nxt.phase)
				PH_HDR: res.swdio_out = nxt.header_byte[nxt.bit_count[2:0]];
				PH_ACK: begin
					res.swdio_drive = 1'b0;
					ack_pos = nxt.bit_count - {{(CountW-3){1'b0}}, turn};
					if (nxt.bit_count >= {{(CountW-3){1'b0}}, turn} && ack_pos < 8'd3) begin
						nxt.ack_reg[ack_pos[1:0]] = nxt.ack_reg[ack_pos[1:0]] | swdio_in;
					end
				end
				PH_RDATA: begin
					res.swdio_drive = 1'b0;
					nxt.shift_reg[nxt.bit_count[4:0]] =
						nxt.shift_reg[nxt.bit_count[4:0]] | swdio_in;
					nxt.parity_acc = nxt.parity_acc ^ swdio_in;
				end
				PH_RPAR: begin
					res.swdio_drive = 1'b0;
					nxt.parity_acc = nxt.parity_acc ^ swdio_in;
				end
				PH_WDATA: res.swdio_out = nxt.shift_reg[nxt.bit_count[4:0]];
				PH_WPAR: res.swdio_out = nxt.parity_acc;
				PH_IDLEZ, PH_DUMW: ;
				default: res.swdio_drive = 1'b0;
			endcase

			case (nxt.phase)
				PH_HDR: len = 9'd8;
				PH_ACK: len = {6'd0, turn} + 9'd3;
				PH_RDATA, PH_WDATA: len = 9'd32;
				PH_IDLEZ: len = {1'b0, cfg.idle_count};
				PH_DUMR, PH_DUMW: len = 9'd33;
				PH_BACKOFF: len = {6'd0, turn} + 9'd33;
				PH_RTURN, PH_WTURN, PH_TURN, PH_TURNW: len = {6'd0, turn};
				default: len = 9'd1;
			endcase

			case (nxt.phase)
				PH_HDR: np = PH_ACK;
				PH_ACK: begin
					if (nxt.ack_reg == ACK_OK) begin
						np = nxt.req_is_read ? PH_RDATA : PH_WTURN;
					end else if (nxt.ack_reg == ACK_WAIT || nxt.ack_reg == ACK_FAULT) begin
						if (cfg.force_data_phase) begin
							np = nxt.req_is_read ? PH_DUMR : PH_TURNW;
						end else begin
							np = PH_TURN;
						end
					end else begin
						np = PH_BACKOFF;
					end
				end
				PH_RDATA: np = PH_RPAR;
				PH_RPAR: np = PH_RTURN;
				PH_RTURN: np = PH_IDLEZ;
				PH_WTURN: np = PH_WDATA;
				PH_WDATA: np = PH_WPAR;
				PH_WPAR: np = PH_IDLEZ;
				PH_DUMR: np = PH_TURN;
				PH_TURNW: np = PH_DUMW;
				default: np = PH_IDLE;
			endcase

			// an empty idle tail is skipped
			if (np == PH_IDLEZ && cfg.idle_count == '0) begin
				np = PH_IDLE;
			end

			cnt_inc = {1'b0, nxt.bit_count} + 9'd1;
			if (cnt_inc >= len) begin
				nxt.phase = np;
				nxt.bit_count = '0;
				done = (np == PH_IDLE);
			end else begin
				nxt.bit_count = cnt_inc[CountW-1:0];
			end

			if (done) begin
				res.done_res = 1'b1;
				if (nxt.ack_reg == ACK_OK) begin
					res.status = (nxt.req_is_read && nxt.parity_acc) ? ST_PARITY : ST_OK;
					res.rdata  = nxt.req_is_read ? nxt.shift_reg : '0;
				end else if (nxt.ack_reg == ACK_WAIT) begin
					res.status = ST_WAIT;
				end else if (nxt.ack_reg == ACK_FAULT) begin
					res.status = ST_FAULT;
				end else begin
					res.status = ST_PROTOCOL;
				end
			end
		end
	end

endmodule

`default_nettype wire
